// ===== sv/efws_pkg.sv =====
// Shared constants and types for the earliest-free worker scheduler.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package efws_pkg;

    localparam int MAX_WORKERS = 16;
    localparam int TIME_W      = 48;
    localparam int DUR_W       = 32;
    localparam int NW_W        = 5;
    localparam int OUT_ID_W    = 4;
    localparam int ID_W        = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
    localparam int LVLS        = $clog2(MAX_WORKERS);
    localparam int PAD         = 2 ** LVLS;
    localparam int LVL_W       = (LVLS > 1) ? $clog2(LVLS) : 1;

    localparam logic [NW_W-1:0] NW_RESET = NW_W'(16);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture duration and snapshot free times
        logic reduce;  // one level of the min tree
        logic commit;  // write back free time and load the output word
    } t_cmd;

    // One candidate in the min tree
    typedef struct packed {
        logic              vld;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] tm;
    } t_cand;

endpackage

`default_nettype wire

// ===== sv/efws_dp.sv =====
// Datapath: worker free times, worker count register, min tree and output word.
// Depends on efws_pkg; driven by commands from efws_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module efws_dp import efws_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [DUR_W-1:0]    i_job_duration,
    input  logic                i_cfg_we,
    input  logic [NW_W-1:0]     i_cfg_num_workers,
    output logic [OUT_ID_W-1:0] o_worker_id,
    output logic [TIME_W-1:0]   o_start_time
);

    logic [NW_W-1:0]   r_nw;
    logic [TIME_W-1:0] r_free [MAX_WORKERS];
    t_cand             r_cand [PAD];
    t_cand             n_load [PAD];
    t_cand             n_red  [PAD];
    logic [DUR_W-1:0]  r_dur;
    logic [OUT_ID_W-1:0] r_out_id;
    logic [TIME_W-1:0] r_out_time;
    logic [CNT_W-1:0]  w_cnt;
    logic [TIME_W:0]   w_sum;
    logic [TIME_W-1:0] w_sat;

    // A valid upper candidate wins if it is strictly earlier or the lower one is invalid; lower id wins a tie
    function automatic t_cand pick(input t_cand a, input t_cand b);
        t_cand r;
        if (b.vld && (!a.vld || (b.tm < a.tm))) begin
            r = b;
        end else begin
            r = a;
        end
        return r;
    endfunction

    // Effective worker count: zero means one, clamp at the worker limit
    always_comb begin
        if (r_nw == '0) begin
            w_cnt = CNT_W'(1);
        end else if (32'(r_nw) > 32'(MAX_WORKERS)) begin
            w_cnt = CNT_W'(MAX_WORKERS);
        end else begin
            w_cnt = CNT_W'(r_nw);
        end
    end

    for (genvar g = 0; g < PAD; g++) begin : g_load
        if (g < MAX_WORKERS) begin : g_real
            assign n_load[g].vld = (32'(g) < 32'(w_cnt));
            assign n_load[g].id  = ID_W'(g);
            assign n_load[g].tm  = r_free[g];
        end else begin : g_pad
            assign n_load[g].vld = 1'b0;
            assign n_load[g].id  = ID_W'(0);
            assign n_load[g].tm  = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < PAD; i++) begin
            n_red[i] = r_cand[i];
        end
        for (int i = 0; i < PAD / 2; i++) begin
            n_red[i] = pick(r_cand[2*i], r_cand[2*i+1]);
        end
    end

    assign w_sum = {1'b0, r_cand[0].tm} + (TIME_W+1)'(r_dur);
    assign w_sat = w_sum[TIME_W] ? {TIME_W{1'b1}} : w_sum[TIME_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nw <= NW_RESET;
            for (int k = 0; k < MAX_WORKERS; k++) begin
                r_free[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_nw <= i_cfg_num_workers;
            end
            if (i_cmd.commit) begin
                r_free[r_cand[0].id] <= w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dur  <= i_job_duration;
            r_cand <= n_load;
        end else if (i_cmd.reduce) begin
            r_cand <= n_red;
        end
        if (i_cmd.commit) begin
            r_out_id   <= OUT_ID_W'(r_cand[0].id);
            r_out_time <= r_cand[0].tm;
        end
    end

    assign o_worker_id  = r_out_id;
    assign o_start_time = r_out_time;

endmodule

`default_nettype wire

// ===== sv/efws_ctrl.sv =====
// Controller: sequences load, tree levels and commit; owns the output valid flag.
// Depends on efws_pkg; drives efws_dp through t_cmd.
`timescale 1ns / 1ps
`default_nettype none

module efws_ctrl import efws_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_REDUCE = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic             r_out_valid;
    logic             w_accept;
    logic             w_slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    assign o_cmd.load   = w_accept;
    assign o_cmd.reduce = (r_state == S_REDUCE);
    assign o_cmd.commit = (r_state == S_COMMIT) && w_slot_free;

    always_comb begin
        n_state = r_state;
        n_lvl   = r_lvl;
        unique case (r_state)
            S_IDLE: begin
                n_lvl = '0;
                if (w_accept) begin
                    n_state = (LVLS == 0) ? S_COMMIT : S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (r_lvl == LVL_W'(LVLS - 1)) begin
                    n_state = S_COMMIT;
                end else begin
                    n_lvl = r_lvl + LVL_W'(1);
                end
            end
            S_COMMIT: begin
                // hold until the output word slot is free
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== sv/earliest_free_worker_scheduler.sv =====
// Top level of the earliest-free worker scheduler: controller plus datapath.
// Depends on efws_pkg, efws_ctrl and efws_dp.
//
//  channel  direction  handshake                     word
//  in       input      i_in_valid  / o_in_ready      i_job_duration
//  out      output     o_out_valid / i_out_ready     o_worker_id, o_start_time
//  cfg      input      i_cfg_valid / o_cfg_ready     i_cfg_num_workers
//
// One job is in flight at a time; the accept edge snapshots the free times, the
// shared min tree then reduces one level at a time, and a commit writes the new
// free time and loads the registered output word. A new job is taken the cycle
// after commit. Commit waits while the output word is still pending. Reset
// (synchronous, active low) clears all free times and sets the count to 16.
`timescale 1ns / 1ps
`default_nettype none

module earliest_free_worker_scheduler import efws_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [DUR_W-1:0]    i_job_duration,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OUT_ID_W-1:0] o_worker_id,
    output logic [TIME_W-1:0]   o_start_time,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [NW_W-1:0]     i_cfg_num_workers
);

    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    efws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    efws_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_job_duration    (i_job_duration),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_num_workers (i_cfg_num_workers),
        .o_worker_id       (o_worker_id),
        .o_start_time      (o_start_time)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a job is in flight");

    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!o_out_valid || i_out_ready))
        else $error("commit overwrites a pending output word");

    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.commit))
        else $error("output valid without a commit");

endmodule

`default_nettype wire
